// ----- hdl/c3rd_pkg.sv -----
package c3rd_pkg;

   localparam int NumWeights = 89;
   localparam int BiasBase   = 72;
   localparam int OutBase    = 80;
   localparam int OutBias    = 88;
   localparam int Taps       = 9;
   localparam int Chans      = 8;
   localparam int QueueDepth = 4;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   typedef logic signed [15:0] smp_type;

   // One pixel job handed from the front to the back: 3x3 window, column, last flag.
   typedef struct packed {
      smp_type [2:0][2:0] win;   // [kx][ky]
      logic [11:0]        col;
      logic               last;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HID,
      BK_OUT,
      BK_DONE
   } bk_state_type;

endpackage

// ----- hdl/c3rd_front.sv -----
module c3rd_front
   import c3rd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [12:0] image_width,
   input  logic        pix_valid,
   output logic        pix_stall,
   input  smp_type     s_above,
   input  smp_type     s_center,
   input  smp_type     s_below,
   output logic        job_push,
   output job_type     job_data,
   input  logic [2:0]  q_free
);

   smp_type [2:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [11:0]   cnt_ff, cnt_in;
   logic [16:0]   width;
   logic [16:0]   x1;
   logic          last;
   logic [1:0]    need;
   smp_type [2:0] cur;
   logic          fire;
   logic          busy_ff, busy_in;
   job_type       pend_ff, pend_in;

   assign cur = {s_below, s_center, s_above};

   always_comb begin
      width = (image_width == 13'd0) ? 17'd1 : {4'd0, image_width};
      if (width > 17'(MAX_WIDTH)) width = 17'(MAX_WIDTH);
      x1   = {5'd0, cnt_ff} + 17'd1;
      last = x1 >= width;
      need = 2'(cnt_ff != 12'd0) + 2'(last);
   end

   // a second job of the same column is held in pend_ff and pushed in the next cycle
   assign pix_stall = busy_ff || (q_free < 3'(need));
   assign fire      = pix_valid && !pix_stall;

   always_comb begin
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      cnt_in   = cnt_ff;
      busy_in  = 1'b0;
      pend_in  = pend_ff;
      job_push = 1'b0;
      job_data = pend_ff;
      if (busy_ff) begin
         job_push = 1'b1;
      end else if (fire) begin
         pend_in.win[0] = (cnt_ff != 12'd0) ? p1_ff : cur;
         pend_in.win[1] = cur;
         pend_in.win[2] = cur;
         pend_in.col    = cnt_ff;
         pend_in.last   = 1'b1;
         if (cnt_ff != 12'd0) begin
            job_push       = 1'b1;
            job_data.win[0] = (cnt_ff == 12'd1) ? p1_ff : p2_ff;
            job_data.win[1] = p1_ff;
            job_data.win[2] = cur;
            job_data.col    = cnt_ff - 12'd1;
            job_data.last   = 1'b0;
            busy_in         = last;
         end else if (last) begin
            job_push = 1'b1;
            job_data = pend_in;
         end
         p2_in  = p1_ff;
         p1_in  = cur;
         cnt_in = last ? 12'd0 : x1[11:0];
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         p1_ff   <= '0;
         p2_ff   <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

`ifndef SYNTH
   a_busy_once: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff) else $error("double pending job");
   a_busy_push: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> job_push) else $error("pending job not pushed");
   a_busy_last: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pend_ff.last) else $error("pending job not last");
`endif

endmodule

// ----- hdl/c3rd_queue.sv -----
module c3rd_queue
   import c3rd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  job_type    din,
   input  logic       pop,
   output logic       nonempty,
   output job_type    dout,
   output logic [2:0] free
);

   job_type     mem [QueueDepth];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;

   assign nonempty = cnt_ff != 3'd0;
   assign dout     = mem[rp_ff];
   assign free     = 3'(QueueDepth) - cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= din;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

`ifndef SYNTH
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 3'(QueueDepth) || pop)) else $error("queue overflow");
   a_no_under: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty) else $error("queue underflow");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QueueDepth)) else $error("queue count");
`endif

endmodule

// ----- hdl/c3rd_back.sv -----
module c3rd_back
   import c3rd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  logic [6:0]   wr_idx,
   input  smp_type      wr_val,
   input  logic         q_nonempty,
   input  job_type      q_data,
   output logic         q_pop,
   output logic         idle,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [12:0]  rsp_denoised,
   output logic [19:0]  rsp_hidden [Chans],
   output logic [11:0]  rsp_pixel_column,
   output logic         rsp_row_done
);

   localparam logic signed [47:0] Half = 48'sd2048;

   smp_type       wmem [NumWeights];
   bk_state_type  st_ff, st_in;
   job_type       job_ff, job_in;
   logic [3:0]    tap_ff, tap_in;
   logic [2:0]    ch_ff, ch_in;
   logic [6:0]    ridx;
   smp_type       w_ff;
   logic signed [47:0] acc_ff, acc_in, corr_ff, corr_in;
   logic [19:0]   hid_ff [Chans];
   logic [19:0]   hid_in [Chans];
   logic signed [16:0] smp;
   logic signed [47:0] prod, hsum, hsh, tot, dsh;
   logic [19:0]   hval;
   logic [12:0]   dval;
   logic          first;
   logic [1:0]    kx, ky;
   logic          out_ld;

   assign idle = st_ff == BK_IDLE;

   // weight read: address set in the cycle before the data is used, data registered
   always_ff @(posedge clock) begin
      if (wr_en && wr_idx < 7'(NumWeights)) wmem[wr_idx] <= wr_val;
      w_ff <= wmem[ridx];
   end

   always_comb begin
      ky   = (tap_ff >= 4'd6) ? 2'd2 : (tap_ff >= 4'd3) ? 2'd1 : 2'd0;
      kx   = 2'(tap_ff - 4'(ky) * 4'd3);
      smp  = 17'(job_ff.win[kx][ky]) - 17'sd2048;
      prod = 48'(smp) * 48'(w_ff);
      hsum = acc_ff + prod;
      hsh  = (hsum + Half) >>> 12;
      if (hsh < 0) hval = '0;
      else if (hsh > 48'sd1048575) hval = 20'hFFFFF;
      else hval = hsh[19:0];
      tot  = (48'(job_ff.win[1][1]) + 48'(w_ff)) * 48'sd4096 + corr_ff;
      dsh  = (tot + Half) >>> 12;
      if (dsh < 0) dval = '0;
      else if (dsh > 48'sd4096) dval = 13'd4096;
      else dval = dsh[12:0];
   end

   // schedule: per channel read bias then taps 0..8; then output weights, then output bias
   always_comb begin
      st_in   = st_ff;
      job_in  = job_ff;
      tap_in  = tap_ff;
      ch_in   = ch_ff;
      acc_in  = acc_ff;
      corr_in = corr_ff;
      hid_in  = hid_ff;
      q_pop   = 1'b0;
      out_ld  = 1'b0;
      ridx    = 7'(BiasBase);
      first   = 1'b0;
      case (st_ff)
         BK_IDLE: begin
            ridx = 7'(BiasBase);
            if (q_nonempty && !(rsp_valid && rsp_stall)) begin
               q_pop   = 1'b1;
               job_in  = q_data;
               ch_in   = '0;
               tap_in  = 4'd15;
               corr_in = '0;
               st_in   = BK_HID;
            end
         end
         BK_HID: begin
            if (tap_ff == 4'd15) begin
               acc_in = 48'(w_ff) * 48'sd4096;
               tap_in = '0;
               ridx   = 7'(ch_ff) * 7'(Taps);
               first  = 1'b1;
            end else if (tap_ff == 4'd8) begin
               hid_in[ch_ff] = hval;
               corr_in = corr_ff;
               acc_in  = '0;
               if (ch_ff == 3'(Chans - 1)) begin
                  tap_in = '0;
                  ch_in  = '0;
                  st_in  = BK_OUT;
                  ridx   = 7'(OutBase);
               end else begin
                  ch_in  = ch_ff + 3'd1;
                  tap_in = 4'd15;
                  ridx   = 7'(BiasBase) + 7'(ch_ff) + 7'd1;
               end
            end else begin
               acc_in = hsum;
               tap_in = tap_ff + 4'd1;
               ridx   = 7'(ch_ff) * 7'(Taps) + 7'(tap_ff) + 7'd1;
            end
         end
         BK_OUT: begin
            corr_in = corr_ff + 48'(signed'({1'b0, hid_ff[ch_ff]})) * 48'(w_ff);
            ch_in   = ch_ff + 3'd1;
            ridx    = (ch_ff == 3'(Chans - 1)) ? 7'(OutBias)
                                               : 7'(OutBase) + 7'(ch_ff) + 7'd1;
            if (ch_ff == 3'(Chans - 1)) st_in = BK_DONE;
         end
         BK_DONE: begin
            out_ld = 1'b1;
            st_in  = BK_IDLE;
         end
         default: st_in = BK_IDLE;
      endcase
      if (st_ff == BK_IDLE && q_pop) ridx = 7'(BiasBase);
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      tap_ff  <= tap_in;
      ch_ff   <= ch_in;
      acc_ff  <= acc_in;
      corr_ff <= corr_in;
      hid_ff  <= hid_in;
      if (out_ld) begin
         rsp_denoised     <= dval;
         rsp_hidden       <= hid_ff;
         rsp_pixel_column <= job_ff.col;
         rsp_row_done     <= job_ff.last;
      end
      if (reset) begin
         st_ff     <= BK_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (out_ld) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

`ifndef SYNTH
   a_ld_free: assert property (@(posedge clock) disable iff (reset)
      out_ld |-> !(rsp_valid && rsp_stall)) else $error("result overwritten");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == BK_IDLE) else $error("pop while busy");
   a_first_tap: assert property (@(posedge clock) disable iff (reset)
      first |=> tap_ff == 4'd0) else $error("tap sequence");
`endif

endmodule

// ----- hdl/conv3x3_relu_denoise_stream_top.sv -----
// channel | direction | handshake     | payload
// req     | in        | valid / stall | action, weight_index/value, three samples
// rsp     | out       | valid / stall | denoised, hidden_0..7, pixel_column, row_done
// csr     | in        | valid / ready | image_width
// A pixel job in the back end walks 8 biases and 72 taps through one multiply-accumulate,
// then 8 output terms through a second one and the output bias, one weight read a cycle.
// A column yields up to two jobs; the front stalls when the 4-entry queue lacks room or a second job is pending.
// Weight loads stall until no pixel job is in flight, then are written to the weight store.
// Reset is synchronous and clears control state; the weight store is undefined until written.
module conv3x3_relu_denoise_stream_top
   import c3rd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_action,
   input  logic [6:0]   req_weight_index,
   input  logic signed [15:0] req_weight_value,
   input  logic signed [15:0] req_sample_above,
   input  logic signed [15:0] req_sample_center,
   input  logic signed [15:0] req_sample_below,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [12:0]  rsp_denoised,
   output logic [19:0]  rsp_hidden_0,
   output logic [19:0]  rsp_hidden_1,
   output logic [19:0]  rsp_hidden_2,
   output logic [19:0]  rsp_hidden_3,
   output logic [19:0]  rsp_hidden_4,
   output logic [19:0]  rsp_hidden_5,
   output logic [19:0]  rsp_hidden_6,
   output logic [19:0]  rsp_hidden_7,
   output logic [11:0]  rsp_pixel_column,
   output logic         rsp_row_done,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [12:0]  csr_image_width
);

   logic [12:0] width_ff;
   logic        pix_stall, push, nonempty, pop;
   logic        back_idle;
   job_type     jd, qd;
   logic [2:0]  free;
   logic [19:0] hid [Chans];

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) width_ff <= 13'd1;
      else if (csr_valid) width_ff <= csr_image_width;
   end

   // hold a weight load while any pixel job is still in flight
   assign req_stall = (req_action == ACT_PIXEL) ? pix_stall
                                                : (push || nonempty || !back_idle);

   c3rd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock, .reset, .image_width(width_ff),
      .pix_valid(req_valid && req_action == ACT_PIXEL), .pix_stall,
      .s_above(req_sample_above), .s_center(req_sample_center),
      .s_below(req_sample_below), .job_push(push), .job_data(jd), .q_free(free)
   );

   c3rd_queue u_queue (
      .clock, .reset, .push, .din(jd), .pop, .nonempty, .dout(qd), .free
   );

   c3rd_back u_back (
      .clock, .reset,
      .wr_en(req_valid && req_action == ACT_LOAD && !req_stall), .wr_idx(req_weight_index),
      .wr_val(req_weight_value), .q_nonempty(nonempty), .q_data(qd), .q_pop(pop),
      .idle(back_idle),
      .rsp_valid, .rsp_stall, .rsp_denoised, .rsp_hidden(hid),
      .rsp_pixel_column, .rsp_row_done
   );

   assign rsp_hidden_0 = hid[0];
   assign rsp_hidden_1 = hid[1];
   assign rsp_hidden_2 = hid[2];
   assign rsp_hidden_3 = hid[3];
   assign rsp_hidden_4 = hid[4];
   assign rsp_hidden_5 = hid[5];
   assign rsp_hidden_6 = hid[6];
   assign rsp_hidden_7 = hid[7];

`ifndef SYNTH
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_action == ACT_LOAD && !req_stall) |-> (back_idle && !nonempty))
      else $error("load while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_width: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(width_ff)) else $error("width changed");
`endif

endmodule
